FILE: rtl/binary_search_first_last_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the sorted-table search core
// Concurrent assertion wrappers; define NO_ASSERTIONS to compile them out.
// ----------------------------------------------------------------------------
`ifndef BINARY_SEARCH_FIRST_LAST_CORE_ASSERT_SVH
`define BINARY_SEARCH_FIRST_LAST_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Checked on every rising edge of clk, ignored while rst_n is low.
`define BSFL_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("bsfl assertion failed");

// Checked on every rising edge of clk, reset included.
`define BSFL_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("bsfl assertion failed");

`else

`define BSFL_ASSERT(label, clk, rst_n, prop)
`define BSFL_ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

FILE: rtl/bsfl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsfl_pkg
// Types and codes shared by the sorted-table search core and its channels.
// ----------------------------------------------------------------------------
package bsfl_pkg;

    localparam int MODE_W      = 2;
    localparam int INDEX_W     = 8;
    localparam int ITEM_W      = 32;
    localparam int STATUS_W    = 2;
    localparam int POS_W       = 8;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 9;
    localparam int COUNT_W     = 9;

    typedef enum logic [MODE_W-1:0] {
        MODE_WRITE = 2'd0,
        MODE_FIRST = 2'd1,
        MODE_LAST  = 2'd2
    } t_mode;

    typedef enum logic [STATUS_W-1:0] {
        STAT_WRITE_DONE = 2'd0,
        STAT_FOUND      = 2'd1,
        STAT_NOT_FOUND  = 2'd2,
        STAT_EMPTY      = 2'd3
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENTRIES_IN_USE = 2'd0,
        CFG_SIGNED_ORDER   = 2'd1
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_CHECK,
        ST_DONE
    } t_state;

endpackage

FILE: rtl/bsfl_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsfl channel interfaces
// Valid/ready channels for query words, result words and register writes.
// ----------------------------------------------------------------------------
interface bsfl_in_if;
    logic                              valid;
    logic                              ready;
    logic [bsfl_pkg::MODE_W-1:0]       mode;
    logic [bsfl_pkg::INDEX_W-1:0]      entry_index;
    logic [bsfl_pkg::ITEM_W-1:0]       item_value;

    modport source (output valid, mode, entry_index, item_value, input ready);
    modport sink   (input valid, mode, entry_index, item_value, output ready);
endinterface

interface bsfl_out_if;
    logic                              valid;
    logic                              ready;
    logic [bsfl_pkg::STATUS_W-1:0]     status;
    logic [bsfl_pkg::POS_W-1:0]        position;

    modport source (output valid, status, position, input ready);
    modport sink   (input valid, status, position, output ready);
endinterface

interface bsfl_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [bsfl_pkg::CFG_IDX_W-1:0]    index;
    logic [bsfl_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/bsfl_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsfl_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module bsfl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

FILE: rtl/binary_search_first_last_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_search_first_last_core
// Sorted-table store with lower/upper bound binary search queries.
// ----------------------------------------------------------------------------
//  channel   direction  carries
//  i_cfg     in         register index, data (0 entries_in_use, 1 signed_order)
//  i_in      in         mode, entry_index, item_value
//  o_out     out        status, position
//
// A write, an unused mode or an empty-table query goes straight to the done
// state on acceptance, which then loads its result word into the output
// register. A find query makes one table read per probe, set by the single
// read port of the table RAM, then the final equality read in the check
// state, then the result load. The next word is taken the cycle after the
// result load. One query is in flight at a time; a result waiting in the
// output register holds the next result back but not the next acceptance.
// Reset clears the control state and registers; the table is not cleared.
// ----------------------------------------------------------------------------
`include "binary_search_first_last_core_assert.svh"

module binary_search_first_last_core #(
    parameter int TABLE_DEPTH = 256,
    parameter int VALUE_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bsfl_cfg_if.sink    i_cfg,
    bsfl_in_if.sink     i_in,
    bsfl_out_if.source  o_out
);
    import bsfl_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int NW = (AW + 1 > COUNT_W) ? AW + 1 : COUNT_W;
    localparam int IW = (AW + 1 > INDEX_W) ? AW + 1 : INDEX_W;
    localparam int VW = VALUE_WIDTH;

    // Registers and state
    t_state                r_state, n_state;
    logic [COUNT_W-1:0]    r_entries;
    logic                  r_signed;
    logic [AW-1:0]         r_left, n_left;
    logic [AW-1:0]         r_right, n_right;
    logic [AW-1:0]         r_mid, n_mid;
    logic                  r_last, n_last;
    logic [VW-1:0]         r_key, n_key;
    logic [STATUS_W-1:0]   r_status, n_status;
    logic [POS_W-1:0]      r_pos, n_pos;
    logic                  r_out_valid, n_out_valid;
    logic [STATUS_W-1:0]   r_out_status, n_out_status;
    logic [POS_W-1:0]      r_out_pos, n_out_pos;

    // Table RAM port
    logic                  w_we;
    logic [AW-1:0]         w_waddr;
    logic [VW-1:0]         w_wdata;
    logic                  w_re;
    logic [AW-1:0]         w_raddr;
    logic [VW-1:0]         w_rdata;

    // Datapath
    logic [NW-1:0]         w_cnt;
    logic [NW-1:0]         w_n;
    logic [VW-1:0]         w_flip;
    logic [VW-1:0]         w_ka;
    logic [VW-1:0]         w_kb;
    logic [AW-1:0]         w_nl;
    logic [AW-1:0]         w_nr;
    logic                  w_nlast;
    logic [AW:0]           w_sum;
    logic                  w_accept;

    bsfl_ram #(
        .WIDTH (VW),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign i_cfg.ready    = 1'b1;
    assign i_in.ready     = (r_state == ST_IDLE);
    assign o_out.valid    = r_out_valid;
    assign o_out.status   = r_out_status;
    assign o_out.position = r_out_pos;
    assign w_accept       = i_in.valid && i_in.ready;

    // Entry count, clamped to the table depth.
    assign w_cnt = NW'(r_entries);
    assign w_n   = (w_cnt > NW'(TABLE_DEPTH)) ? NW'(TABLE_DEPTH) : w_cnt;

    // Flipping the top bit turns a two's complement order into an unsigned one.
    assign w_flip = VW'(r_signed) << (VW - 1);
    assign w_ka   = w_rdata ^ w_flip;
    assign w_kb   = r_key ^ w_flip;

    // Midpoint of the window about to be probed; the upper-bound search rounds up.
    assign w_sum = {1'b0, w_nl} + {1'b0, w_nr} + (AW + 1)'(w_nlast);

    always_comb begin
        n_state      = r_state;
        n_left       = r_left;
        n_right      = r_right;
        n_mid        = r_mid;
        n_last       = r_last;
        n_key        = r_key;
        n_status     = r_status;
        n_pos        = r_pos;
        n_out_valid  = r_out_valid && !o_out.ready;
        n_out_status = r_out_status;
        n_out_pos    = r_out_pos;
        w_we         = 1'b0;
        w_waddr      = AW'(i_in.entry_index);
        w_wdata      = VW'(i_in.item_value);
        w_re         = 1'b0;
        w_nl         = r_left;
        w_nr         = r_right;
        w_nlast      = r_last;

        unique case (r_state)
            ST_IDLE: begin
                w_nl    = '0;
                w_nr    = AW'(w_n - NW'(1));
                w_nlast = (i_in.mode == MODE_LAST);
                if (w_accept) begin
                    n_key    = VW'(i_in.item_value);
                    n_last   = w_nlast;
                    n_status = STAT_WRITE_DONE;
                    n_pos    = '0;
                    n_state  = ST_DONE;
                    case (i_in.mode)
                        MODE_WRITE: begin
                            w_we = (IW'(i_in.entry_index) < IW'(TABLE_DEPTH));
                        end
                        MODE_FIRST, MODE_LAST: begin
                            if (w_n == '0) begin
                                n_status = STAT_EMPTY;
                            end else begin
                                w_re = 1'b1;
                            end
                        end
                        default: begin
                            n_status = STAT_WRITE_DONE;
                        end
                    endcase
                end
            end
            ST_SEARCH: begin
                // The word for r_mid is on the read port this cycle.
                if (r_last) begin
                    if (w_ka > w_kb) begin
                        w_nr = r_mid - AW'(1);
                    end else begin
                        w_nl = r_mid;
                    end
                end else begin
                    if (w_ka < w_kb) begin
                        w_nl = r_mid + AW'(1);
                    end else begin
                        w_nr = r_mid;
                    end
                end
                w_re = 1'b1;
            end
            ST_CHECK: begin
                if (w_ka == w_kb) begin
                    n_status = STAT_FOUND;
                    n_pos    = POS_W'(r_left);
                end else begin
                    n_status = STAT_NOT_FOUND;
                    n_pos    = '0;
                end
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_pos    = r_pos;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // Issue the next read: a probe while the window is open, else the final check.
        if (w_re) begin
            n_left  = w_nl;
            n_right = w_nr;
            if (w_nl < w_nr) begin
                n_mid   = w_sum[AW:1];
                w_raddr = w_sum[AW:1];
                n_state = ST_SEARCH;
            end else begin
                n_mid   = w_nl;
                w_raddr = w_nl;
                n_state = ST_CHECK;
            end
        end else begin
            w_raddr = w_nl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_entries   <= '0;
            r_signed    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg.valid && i_cfg.ready) begin
                if (i_cfg.index == CFG_ENTRIES_IN_USE) begin
                    r_entries <= i_cfg.data[COUNT_W-1:0];
                end else if (i_cfg.index == CFG_SIGNED_ORDER) begin
                    r_signed <= i_cfg.data[0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_left       <= n_left;
        r_right      <= n_right;
        r_mid        <= n_mid;
        r_last       <= n_last;
        r_key        <= n_key;
        r_status     <= n_status;
        r_pos        <= n_pos;
        r_out_status <= n_out_status;
        r_out_pos    <= n_out_pos;
    end

    `BSFL_ASSERT(a_search_window_open, i_clk, i_rst_n, (r_state == ST_SEARCH) |-> (r_left < r_right))
    `BSFL_ASSERT(a_search_in_range, i_clk, i_rst_n, (r_state == ST_SEARCH) |-> (NW'(r_right) < w_n))
    `BSFL_ASSERT(a_window_shrinks, i_clk, i_rst_n, (r_state == ST_SEARCH ##1 r_state == ST_SEARCH) |-> ((r_right - r_left) < $past(r_right - r_left)))
    `BSFL_ASSERT(a_position_only_found, i_clk, i_rst_n, (o_out.valid && (o_out.status != STAT_FOUND)) |-> (o_out.position == '0))

endmodule

FILE: tb/sv/binary_search_first_last_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_search_first_last_checker
// Watches the register, query and result channels of the sorted-table search
// core, keeps its own copy of the table and registers, predicts the result
// word of every accepted query word and compares it field by field.
// ----------------------------------------------------------------------------
module binary_search_first_last_checker #(
    parameter int TABLE_DEPTH = 256
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    input  logic                              i_cfg_ready,
    input  logic [bsfl_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [bsfl_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                              i_in_valid,
    input  logic                              i_in_ready,
    input  logic [bsfl_pkg::MODE_W-1:0]       i_in_mode,
    input  logic [bsfl_pkg::INDEX_W-1:0]      i_in_entry_index,
    input  logic [bsfl_pkg::ITEM_W-1:0]       i_in_item_value,
    input  logic                              i_out_valid,
    input  logic                              i_out_ready,
    input  logic [bsfl_pkg::STATUS_W-1:0]     i_out_status,
    input  logic [bsfl_pkg::POS_W-1:0]        i_out_position,
    output int                                o_fail_count,
    output int                                o_pending,
    output int                                o_checked,
    output int                                o_found,
    output int                                o_missed,
    output int                                o_empty
);
    import bsfl_pkg::*;

    typedef struct packed {
        t_status            status;
        logic [POS_W-1:0]   position;
    } t_search_result;

    logic [ITEM_W-1:0]   stored_values [TABLE_DEPTH];
    logic [COUNT_W-1:0]  entry_count;
    logic                signed_cmp;
    t_search_result      awaited_results [$];

    // Flipping the sign bit makes an unsigned compare follow two's complement order.
    function automatic logic [ITEM_W-1:0] order_key(input logic [ITEM_W-1:0] v);
        return v ^ {signed_cmp, {(ITEM_W-1){1'b0}}};
    endfunction

    function automatic t_search_result search_table(input logic find_last,
                                                    input logic [ITEM_W-1:0] key);
        t_search_result     res;
        int                 n;
        int                 lo;
        int                 hi;
        int                 mid;
        logic [ITEM_W-1:0]  k;
        res.status   = STAT_EMPTY;
        res.position = '0;
        n = (entry_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(entry_count);
        if (n == 0) begin
            return res;
        end
        k  = order_key(key);
        lo = 0;
        hi = n - 1;
        while (lo < hi) begin
            if (find_last) begin
                mid = (lo + hi + 1) >> 1;
                if (order_key(stored_values[mid]) > k) begin
                    hi = mid - 1;
                end else begin
                    lo = mid;
                end
            end else begin
                mid = (lo + hi) >> 1;
                if (order_key(stored_values[mid]) < k) begin
                    lo = mid + 1;
                end else begin
                    hi = mid;
                end
            end
        end
        if (order_key(stored_values[lo]) == k) begin
            res.status   = STAT_FOUND;
            res.position = POS_W'(lo);
        end else begin
            res.status = STAT_NOT_FOUND;
        end
        return res;
    endfunction

    function automatic t_search_result apply_word(input logic [MODE_W-1:0] mode,
                                                  input logic [INDEX_W-1:0] idx,
                                                  input logic [ITEM_W-1:0] val);
        t_search_result res;
        res.status   = STAT_WRITE_DONE;
        res.position = '0;
        case (mode)
            MODE_WRITE: begin
                stored_values[idx] = val;
            end
            MODE_FIRST: begin
                res = search_table(1'b0, val);
            end
            MODE_LAST: begin
                res = search_table(1'b1, val);
            end
            default: begin
            end
        endcase
        return res;
    endfunction

    always @(posedge i_clk) begin : monitor
        t_search_result got;
        t_search_result want;
        if (!i_rst_n) begin
            entry_count = '0;
            signed_cmp  = 1'b0;
            awaited_results.delete();
        end else begin
            // A result is never taken on the edge that accepts its query, so the
            // result side is handled before this edge's query word is queued.
            if (i_out_valid && i_out_ready) begin
                got.status   = t_status'(i_out_status);
                got.position = i_out_position;
                o_checked++;
                if (awaited_results.size() == 0) begin
                    $error("result word with nothing awaited: status %0d, position %0d",
                           got.status, got.position);
                    o_fail_count++;
                end else begin
                    want = awaited_results.pop_front();
                    if (got.status !== want.status) begin
                        $error("status mismatch: expected %0d, actual %0d",
                               want.status, got.status);
                        o_fail_count++;
                    end
                    if (got.position !== want.position) begin
                        $error("position mismatch: expected %0d, actual %0d",
                               want.position, got.position);
                        o_fail_count++;
                    end
                    case (want.status)
                        STAT_FOUND:     o_found++;
                        STAT_NOT_FOUND: o_missed++;
                        STAT_EMPTY:     o_empty++;
                        default: begin
                        end
                    endcase
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_ENTRIES_IN_USE: entry_count = i_cfg_data;
                    CFG_SIGNED_ORDER:   signed_cmp  = i_cfg_data[0];
                    default: begin
                    end
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                awaited_results.push_back(apply_word(i_in_mode, i_in_entry_index,
                                                     i_in_item_value));
            end
        end
        o_pending = awaited_results.size();
    end

endmodule

FILE: tb/sv/binary_search_first_last_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_search_first_last_core_tb
// Drives table writes and first/last match queries into the search core under
// changing table sizes and compare orders, with random stalls on both sides,
// and leaves the prediction and comparison to the checker beside the core.
// ----------------------------------------------------------------------------
module binary_search_first_last_core_tb;
    import bsfl_pkg::*;

    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 11;
    localparam int CYCLE_LIMIT   = 500000;
    localparam int LONG_HOLD     = 400;
    localparam int SETTLE_CYCLES = 20;
    localparam int DEPTH         = 256;
    localparam int REGIME_WORDS  = 420;

    localparam logic [MODE_W-1:0]    MODE_UNUSED = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    bsfl_cfg_if cfg_ch ();
    bsfl_in_if  in_ch ();
    bsfl_out_if out_ch ();

    int fail_count;
    int pending_words;
    int checked_words;
    int found_words;
    int missed_words;
    int empty_words;
    int cycle_count   = 0;
    int words_sent    = 0;
    int cfg_writes    = 0;
    int send_idle_pct = 9;
    int recv_idle_pct = 72;
    bit long_hold_req = 1'b0;
    bit signed_now    = 1'b0;

    logic [ITEM_W-1:0] value_image [DEPTH];

    binary_search_first_last_core i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_ch),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    binary_search_first_last_checker #(
        .TABLE_DEPTH (DEPTH)
    ) i_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (cfg_ch.valid),
        .i_cfg_ready      (cfg_ch.ready),
        .i_cfg_index      (cfg_ch.index),
        .i_cfg_data       (cfg_ch.data),
        .i_in_valid       (in_ch.valid),
        .i_in_ready       (in_ch.ready),
        .i_in_mode        (in_ch.mode),
        .i_in_entry_index (in_ch.entry_index),
        .i_in_item_value  (in_ch.item_value),
        .i_out_valid      (out_ch.valid),
        .i_out_ready      (out_ch.ready),
        .i_out_status     (out_ch.status),
        .i_out_position   (out_ch.position),
        .o_fail_count     (fail_count),
        .o_pending        (pending_words),
        .o_checked        (checked_words),
        .o_found          (found_words),
        .o_missed         (missed_words),
        .o_empty          (empty_words)
    );

    always #CLK_HALF i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Returns just after the rising edge that accepted the word; valid stays
    // high until the next falling edge, where the next call takes over.
    task automatic send_word(input logic [MODE_W-1:0] mode,
                             input logic [INDEX_W-1:0] idx,
                             input logic [ITEM_W-1:0] val);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.mode        <= mode;
        in_ch.entry_index <= idx;
        in_ch.item_value  <= val;
        @(posedge i_clk);
        while (!in_ch.ready) begin
            @(posedge i_clk);
        end
        if (mode == MODE_WRITE) begin
            value_image[idx] = val;
        end
        words_sent++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        @(posedge i_clk);
        while (!cfg_ch.ready) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
        cfg_writes++;
    endtask

    // The sender stops until every awaited result word has been taken.
    task automatic drain_results();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (pending_words != 0) begin
            @(negedge i_clk);
        end
    endtask

    // Writes positions 0 .. span-1 ascending in the current compare order.
    task automatic fill_sorted(input int span);
        logic [ITEM_W-1:0] keys [$];
        logic [ITEM_W-1:0] base;
        bit                dense;
        dense = $urandom_range(0, 1);
        base  = $urandom;
        for (int i = 0; i < span; i++) begin
            keys.push_back(dense ? base + ITEM_W'($urandom_range(0, span)) : $urandom);
        end
        keys.sort();
        for (int i = 0; i < span; i++) begin
            if ($urandom_range(0, 19) == 0) begin
                send_word(MODE_UNUSED, INDEX_W'($urandom), $urandom);
            end
            send_word(MODE_WRITE, INDEX_W'(i), keys[i] ^ {signed_now, {(ITEM_W-1){1'b0}}});
        end
    endtask

    function automatic logic [ITEM_W-1:0] pick_key(input int span);
        int roll;
        int pick;
        roll = $urandom_range(0, 99);
        pick = (span > 0) ? $urandom_range(0, span - 1) : 0;
        if (span == 0 || roll >= 80) begin
            return $urandom;
        end
        if (roll < 60) begin
            return value_image[pick];
        end
        return (roll < 70) ? value_image[pick] + 1'b1 : value_image[pick] - 1'b1;
    endfunction

    task automatic run_queries(input int span, input int count);
        int roll;
        for (int i = 0; i < count; i++) begin
            roll = $urandom_range(0, 99);
            if (roll < 5) begin
                send_word(MODE_UNUSED, INDEX_W'($urandom), $urandom);
            end else if (roll < 10) begin
                // A stray write at a random position may leave the used range unsorted.
                send_word(MODE_WRITE, INDEX_W'($urandom), $urandom);
            end else begin
                send_word($urandom_range(0, 1) ? MODE_FIRST : MODE_LAST,
                          INDEX_W'($urandom), pick_key(span));
            end
        end
    endtask

    function automatic int choose_count();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 5) begin
            return 0;
        end else if (roll < 75) begin
            return $urandom_range(1, 16);
        end else if (roll < 95) begin
            return $urandom_range(17, 64);
        end
        return $urandom_range(65, DEPTH - 1);
    endfunction

    task automatic run_episode(input int count, input bit hold);
        int span;
        int queries;
        drain_results();
        signed_now = $urandom_range(0, 1);
        write_reg(CFG_ENTRIES_IN_USE, CFG_DATA_W'(count));
        write_reg(CFG_SIGNED_ORDER, {8'($urandom), signed_now});
        if ($urandom_range(0, 9) == 0) begin
            write_reg($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B,
                      CFG_DATA_W'($urandom));
        end
        span = (count > DEPTH) ? DEPTH : count;
        fill_sorted(span);
        if (span > 1 && $urandom_range(0, 6) == 0) begin
            repeat ($urandom_range(1, 3)) begin
                send_word(MODE_WRITE, INDEX_W'($urandom_range(0, span - 1)), $urandom);
            end
        end
        if (hold) begin
            long_hold_req = 1'b1;
        end
        queries = (span > 16) ? $urandom_range(20, 40) : $urandom_range(6, 20);
        run_queries(span, queries);
    endtask

    initial begin : result_sink
        int hold_left;
        hold_left    = 0;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (long_hold_req) begin
                hold_left     = LONG_HOLD;
                long_hold_req = 1'b0;
            end
            if (hold_left > 0) begin
                out_ch.ready <= 1'b0;
                hold_left--;
            end else begin
                out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    initial begin : stimulus
        int episode;
        int count;
        in_ch.valid       = 1'b0;
        in_ch.mode        = MODE_WRITE;
        in_ch.entry_index = '0;
        in_ch.item_value  = '0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.index      = CFG_ENTRIES_IN_USE;
        cfg_ch.data       = '0;

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Empty table straight after reset, and the unused mode.
        send_word(MODE_FIRST, 8'h00, 32'h0000_0000);
        send_word(MODE_LAST, 8'hFF, 32'hFFFF_FFFF);
        send_word(MODE_UNUSED, 8'hFF, 32'hFFFF_FFFF);

        // Duplicates in the middle, extremes at the ends, and the last position.
        send_word(MODE_WRITE, 8'd0, 32'h0000_0000);
        send_word(MODE_WRITE, 8'd1, 32'h0000_0005);
        send_word(MODE_WRITE, 8'd2, 32'h0000_0005);
        send_word(MODE_WRITE, 8'd3, 32'h0000_0005);
        send_word(MODE_WRITE, 8'd4, 32'hFFFF_FFFF);
        send_word(MODE_WRITE, 8'hFF, 32'hA5A5_A5A5);
        drain_results();
        write_reg(CFG_ENTRIES_IN_USE, 9'd5);
        write_reg(CFG_SPARE_A, 9'h1FF);
        write_reg(CFG_SPARE_B, 9'h1FF);
        send_word(MODE_FIRST, 8'h00, 32'h0000_0005);
        send_word(MODE_LAST, 8'hFF, 32'h0000_0005);
        send_word(MODE_FIRST, 8'h55, 32'h0000_0000);
        send_word(MODE_LAST, 8'hAA, 32'hFFFF_FFFF);
        send_word(MODE_FIRST, 8'h0F, 32'h0000_0006);
        send_word(MODE_LAST, 8'hF0, 32'h8000_0000);

        // The same shape in two's complement order.
        drain_results();
        write_reg(CFG_SIGNED_ORDER, 9'h1FF);
        send_word(MODE_WRITE, 8'd0, 32'h8000_0000);
        send_word(MODE_WRITE, 8'd1, 32'hFFFF_FFFF);
        send_word(MODE_WRITE, 8'd2, 32'hFFFF_FFFF);
        send_word(MODE_WRITE, 8'd3, 32'h0000_0000);
        send_word(MODE_WRITE, 8'd4, 32'h7FFF_FFFF);
        send_word(MODE_FIRST, 8'h00, 32'hFFFF_FFFF);
        send_word(MODE_LAST, 8'hFF, 32'hFFFF_FFFF);
        send_word(MODE_FIRST, 8'h33, 32'h8000_0000);
        send_word(MODE_LAST, 8'hCC, 32'h7FFF_FFFF);
        send_word(MODE_FIRST, 8'h01, 32'h0000_0001);

        for (int regime = 0; regime < 3; regime++) begin
            case (regime)
                0: begin
                    send_idle_pct = 9;
                    recv_idle_pct = 72;
                end
                1: begin
                    send_idle_pct = 72;
                    recv_idle_pct = 9;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            episode = 0;
            while (words_sent < (regime + 1) * REGIME_WORDS + 40) begin
                if (episode == 0) begin
                    // Full table, a single entry, and a count beyond the depth.
                    count = (regime == 0) ? DEPTH : ((regime == 1) ? 1 : 511);
                end else begin
                    count = choose_count();
                end
                run_episode(count, regime == 2 && episode == 0);
                episode++;
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        $display("Sent %0d query and write words and %0d register writes; %0d results checked.",
                 words_sent, cfg_writes, checked_words);
        $display("Outcomes: %0d found, %0d not found, %0d empty, in both compare orders.",
                 found_words, missed_words, empty_words);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

FILE: files.f
+incdir+rtl
rtl/bsfl_pkg.sv
rtl/bsfl_if.sv
rtl/bsfl_ram.sv
rtl/binary_search_first_last_core.sv
tb/sv/binary_search_first_last_checker.sv
tb/sv/binary_search_first_last_core_tb.sv
